>>> rtl/icmp_prc_pkg.sv
// ----------------------------------------------------------------------------
// ICMP probe reply classifier package
// Shared constants, verdict codes and the captured-field view type.
// ----------------------------------------------------------------------------
`default_nettype none

package icmp_prc_pkg;

  // ICMP and IPv4 layout
  localparam logic [15:0] ICMP_HDR_BYTES  = 16'd8;
  localparam logic [15:0] UDP_PORT_BYTES  = 16'd4;
  localparam logic [15:0] INNER_MIN_BYTES = 16'd20;
  localparam logic [15:0] PROTO_OFFSET    = 16'd9;

  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] CODE_IN_TRANSIT    = 8'd0;
  localparam logic [7:0] TYPE_UNREACHABLE   = 8'd3;
  localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
  localparam logic [7:0] PROTO_UDP          = 8'd17;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_ROUTER  = 2'd1;
  localparam logic [1:0] VERDICT_REACHED = 2'd2;
  localparam logic [1:0] VERDICT_UNREACH = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_SOURCE_PORT    = 2'd0;
  localparam logic [1:0] REG_DEST_PORT_BASE = 2'd1;
  localparam logic [1:0] REG_PROBE_SEQ      = 2'd2;

  localparam logic [15:0] DEST_PORT_BASE_RESET = 16'd33434;

  // Packet fields as they stand after the current byte
  typedef struct packed {
    logic [15:0] byte_count;
    logic [5:0]  outer_hdr_len;
    logic [7:0]  icmp_type_seen;
    logic [7:0]  icmp_code_seen;
    logic [5:0]  inner_hdr_len;
    logic [7:0]  inner_protocol;
    logic [15:0] udp_src_seen;
    logic [15:0] udp_dst_seen;
  } pkt_view_t;

endpackage

`default_nettype wire

>>> rtl/icmp_prc_capture.sv
// ----------------------------------------------------------------------------
// ICMP probe reply field capture
// Tracks the byte position of the packet and captures the header fields at
// offsets that follow from the outer and inner header length nibbles.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_prc_capture (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             packet_byte,
  input  wire logic                   last_byte,
  output icmp_prc_pkg::pkt_view_t     view
);

  icmp_prc_pkg::pkt_view_t state;

  logic [15:0] pos;
  logic [15:0] icmp_at;
  logic [15:0] inner_at;
  logic [15:0] udp_at;

  always_comb begin
    pos  = state.byte_count;
    view = state;

    if (pos == 16'd0) begin
      view.outer_hdr_len = {packet_byte[3:0], 2'b00};
    end
    icmp_at = {10'd0, view.outer_hdr_len};
    if (pos == icmp_at) begin
      view.icmp_type_seen = packet_byte;
    end
    if (pos == icmp_at + 16'd1) begin
      view.icmp_code_seen = packet_byte;
    end

    inner_at = icmp_at + icmp_prc_pkg::ICMP_HDR_BYTES;
    if (pos == inner_at) begin
      view.inner_hdr_len = {packet_byte[3:0], 2'b00};
    end
    if (pos == inner_at + icmp_prc_pkg::PROTO_OFFSET) begin
      view.inner_protocol = packet_byte;
    end

    // Ports are big-endian; each byte lands on its own
    udp_at = inner_at + {10'd0, view.inner_hdr_len};
    if (pos == udp_at) begin
      view.udp_src_seen[15:8] = packet_byte;
    end
    if (pos == udp_at + 16'd1) begin
      view.udp_src_seen[7:0] = packet_byte;
    end
    if (pos == udp_at + 16'd2) begin
      view.udp_dst_seen[15:8] = packet_byte;
    end
    if (pos == udp_at + 16'd3) begin
      view.udp_dst_seen[7:0] = packet_byte;
    end

    // Saturate the count
    if (pos != icmp_prc_pkg::COUNT_MAX) begin
      view.byte_count = pos + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      // Start afresh after the final byte
      if (last_byte) begin
        state <= '0;
      end else begin
        state <= view;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/icmp_prc_core_top.sv
// ----------------------------------------------------------------------------
// ICMP probe reply classifier
// Classifies a received IPv4 packet, one byte per item, against the current
// UDP traceroute probe and gives one verdict on the final byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one packet byte per item,
//   with last_byte marking the final byte. Only the final byte of a packet
//   yields an item on the output channel (out_valid/out_ready): verdict,
//   unreach_code, msg_type and msg_code.
//   Field capture, length checks and the port compare all settle between the
//   capture registers and the result register, so the sustained rate is one
//   byte per clock while in_ready stays high.
//   The verdict appears on the output in the cycle after the final byte is
//   accepted.
//   The result register parts the two sides: while a verdict waits to be
//   taken, in_ready stays high if out_ready is high, and drops otherwise.
//   Reset clears the packet state and the result valid flag, and loads the
//   configuration registers with source port 0, base port 33434 and
//   sequence 0. Write configuration through cfg_wr_en only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_probe_reply_classifier_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // packet bytes
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        last_byte,
  // verdicts
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       verdict,
  output logic [7:0]       unreach_code,
  output logic [7:0]       msg_type,
  output logic [7:0]       msg_code
);

  logic [15:0] source_port;
  logic [15:0] dest_port_base;
  logic [15:0] probe_seq;

  logic                    accept;
  icmp_prc_pkg::pkt_view_t view;

  logic [16:0] n;
  logic [16:0] l1;
  logic        long_icmp;
  logic        long_inner;
  logic        long_ports;
  logic        texc;
  logic        unr;
  logic        match;
  logic [15:0] want_dst;

  logic [1:0]  verdict_next;
  logic [7:0]  unreach_code_next;
  logic [7:0]  msg_type_next;
  logic [7:0]  msg_code_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_port    <= '0;
      dest_port_base <= icmp_prc_pkg::DEST_PORT_BASE_RESET;
      probe_seq      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        icmp_prc_pkg::REG_SOURCE_PORT:    source_port    <= cfg_data;
        icmp_prc_pkg::REG_DEST_PORT_BASE: dest_port_base <= cfg_data;
        icmp_prc_pkg::REG_PROBE_SEQ:      probe_seq      <= cfg_data;
        default: ;
      endcase
    end
  end

  icmp_prc_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .packet_byte (packet_byte),
    .last_byte   (last_byte),
    .view        (view)
  );

  always_comb begin
    n  = {1'b0, view.byte_count};
    l1 = {11'd0, view.outer_hdr_len};

    long_icmp  = n >= l1 + {1'b0, icmp_prc_pkg::ICMP_HDR_BYTES};
    long_inner = n >= l1 + {1'b0, icmp_prc_pkg::ICMP_HDR_BYTES}
                         + {1'b0, icmp_prc_pkg::INNER_MIN_BYTES};
    long_ports = n >= l1 + {1'b0, icmp_prc_pkg::ICMP_HDR_BYTES}
                         + {1'b0, icmp_prc_pkg::UDP_PORT_BYTES}
                         + {11'd0, view.inner_hdr_len};

    texc = (view.icmp_type_seen == icmp_prc_pkg::TYPE_TIME_EXCEEDED)
        && (view.icmp_code_seen == icmp_prc_pkg::CODE_IN_TRANSIT);
    unr  = view.icmp_type_seen == icmp_prc_pkg::TYPE_UNREACHABLE;

    want_dst = dest_port_base + probe_seq;
    match    = (view.inner_protocol == icmp_prc_pkg::PROTO_UDP)
            && (view.udp_src_seen == source_port)
            && (view.udp_dst_seen == want_dst);

    verdict_next      = icmp_prc_pkg::VERDICT_NONE;
    unreach_code_next = '0;
    msg_type_next     = '0;
    msg_code_next     = '0;

    if (long_icmp) begin
      msg_type_next = view.icmp_type_seen;
      msg_code_next = view.icmp_code_seen;
      if ((texc || unr) && long_inner && long_ports && match) begin
        if (texc) begin
          verdict_next = icmp_prc_pkg::VERDICT_ROUTER;
        end else if (view.icmp_code_seen == icmp_prc_pkg::CODE_PORT_UNREACH) begin
          verdict_next = icmp_prc_pkg::VERDICT_REACHED;
        end else begin
          verdict_next      = icmp_prc_pkg::VERDICT_UNREACH;
          unreach_code_next = view.icmp_code_seen;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload until a new verdict replaces it
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      verdict      <= verdict_next;
      unreach_code <= unreach_code_next;
      msg_type     <= msg_type_next;
      msg_code     <= msg_code_next;
    end
  end

  a_final_gives_result: assert property (
    @(posedge clk) disable iff (rst)
    (accept && last_byte) |=> out_valid
  ) else $error("final byte accepted without a verdict");

  a_match_type: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && verdict != icmp_prc_pkg::VERDICT_NONE) |->
      (msg_type == icmp_prc_pkg::TYPE_TIME_EXCEEDED
       || msg_type == icmp_prc_pkg::TYPE_UNREACHABLE)
  ) else $error("matching verdict on a foreign ICMP type");

  a_code_only_unreach: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && unreach_code != 8'd0) |->
      (verdict == icmp_prc_pkg::VERDICT_UNREACH && unreach_code == msg_code)
  ) else $error("unreachable code given outside an other-unreachable verdict");

  a_reached_code: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && verdict == icmp_prc_pkg::VERDICT_REACHED) |->
      (msg_code == icmp_prc_pkg::CODE_PORT_UNREACH)
  ) else $error("destination reached without port unreachable code");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// ICMP probe reply classifier testbench
// Sends directed and random IPv4 packets as byte items, predicts the verdict
// of each packet in a scoreboard and checks every verdict item that comes
// out. Both sides idle at random; register settings change between phases.
// ----------------------------------------------------------------------------

module testbench;
  import icmp_prc_pkg::*;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] unreach_code;
    logic [7:0] msg_type;
    logic [7:0] msg_code;
  } verdict_t;

  class reply_scoreboard;
    pkt_view_t   pkt;
    logic [15:0] src_port;
    logic [15:0] dest_base;
    logic [15:0] seq;
    verdict_t    pending[$];
    int          errors;
    int          checked;
    int          n_bytes;
    int          n_packets;
    int          verdict_hits[4];

    function new();
      pkt       = '0;
      src_port  = 16'd0;
      dest_base = DEST_PORT_BASE_RESET;
      seq       = 16'd0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_SOURCE_PORT:    src_port = v;
        REG_DEST_PORT_BASE: dest_base = v;
        REG_PROBE_SEQ:      seq = v;
        default: ;
      endcase
    endfunction

    // Capture fields from one accepted byte; on the final byte queue a verdict.
    function void take_byte(logic [7:0] b, logic last);
      int          pos;
      int          icmp_at;
      int          inner_at;
      int          udp_at;
      int          icmplen;
      int          min_icmp;
      int          min_inner;
      int          min_ports;
      logic        texc;
      logic        unr;
      logic [15:0] want_dst;
      verdict_t    want;
      n_bytes++;
      pos = pkt.byte_count;
      if (pos == 0) pkt.outer_hdr_len = {b[3:0], 2'b00};
      icmp_at = pkt.outer_hdr_len;
      if (pos == icmp_at) pkt.icmp_type_seen = b;
      if (pos == icmp_at + 1) pkt.icmp_code_seen = b;
      inner_at = icmp_at + ICMP_HDR_BYTES;
      if (pos == inner_at) pkt.inner_hdr_len = {b[3:0], 2'b00};
      if (pos == inner_at + PROTO_OFFSET) pkt.inner_protocol = b;
      udp_at = inner_at + pkt.inner_hdr_len;
      if (pos == udp_at) pkt.udp_src_seen[15:8] = b;
      if (pos == udp_at + 1) pkt.udp_src_seen[7:0] = b;
      if (pos == udp_at + 2) pkt.udp_dst_seen[15:8] = b;
      if (pos == udp_at + 3) pkt.udp_dst_seen[7:0] = b;
      if (pkt.byte_count != COUNT_MAX) pkt.byte_count = pkt.byte_count + 16'd1;
      if (!last) return;

      want      = '0;
      min_icmp  = ICMP_HDR_BYTES;
      min_inner = ICMP_HDR_BYTES + INNER_MIN_BYTES;
      min_ports = ICMP_HDR_BYTES + UDP_PORT_BYTES + pkt.inner_hdr_len;
      icmplen   = int'(pkt.byte_count) - int'(pkt.outer_hdr_len);
      if (icmplen >= min_icmp) begin
        want.msg_type = pkt.icmp_type_seen;
        want.msg_code = pkt.icmp_code_seen;
        texc = (pkt.icmp_type_seen == TYPE_TIME_EXCEEDED) &&
               (pkt.icmp_code_seen == CODE_IN_TRANSIT);
        unr  = (pkt.icmp_type_seen == TYPE_UNREACHABLE);
        if ((texc || unr) && icmplen >= min_inner && icmplen >= min_ports) begin
          want_dst = dest_base + seq;
          if (pkt.inner_protocol == PROTO_UDP && pkt.udp_src_seen == src_port &&
              pkt.udp_dst_seen == want_dst) begin
            if (texc) begin
              want.verdict = VERDICT_ROUTER;
            end else if (pkt.icmp_code_seen == CODE_PORT_UNREACH) begin
              want.verdict = VERDICT_REACHED;
            end else begin
              want.verdict      = VERDICT_UNREACH;
              want.unreach_code = pkt.icmp_code_seen;
            end
          end
        end
      end
      pending.push_back(want);
      verdict_hits[want.verdict]++;
      n_packets++;
      pkt = '0;
    endfunction

    function void check_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: verdict item with none expected: expected nothing, got %p",
                 $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      check_field("verdict", want.verdict, got.verdict);
      check_field("unreach_code", want.unreach_code, got.unreach_code);
      check_field("msg_type", want.msg_type, got.msg_type);
      check_field("msg_code", want.msg_code, got.msg_code);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  packet_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  verdict;
  logic [7:0]  unreach_code;
  logic [7:0]  msg_type;
  logic [7:0]  msg_code;

  reply_scoreboard sb = new();
  logic [7:0]      frame[$];
  int              send_gap_max = 5;
  int              recv_gap_max = 5;
  int              reg_writes;

  always #5 clk = ~clk;

  icmp_probe_reply_classifier_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .packet_byte  (packet_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .unreach_code (unreach_code),
    .msg_type     (msg_type),
    .msg_code     (msg_code)
  );

  // Each call starts and ends on a falling edge, so valid stays up between
  // back-to-back items.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    packet_byte = b;
    last_byte   = last;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_reg(idx, v);
    reg_writes++;
  endtask

  // Drop valid, let every verdict out and give the pipeline time to settle.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] probe_port();
    return sb.dest_base + sb.seq;
  endfunction

  // Lay out a reply: outer header, ICMP header, quoted header, UDP ports and
  // a trailer. Fields are written in capture order, so overlaps overwrite.
  task automatic build_reply(input int ihl1, input int ihl2, input logic [7:0] typ,
                             input logic [7:0] cod, input logic [7:0] prot,
                             input logic [15:0] src, input logic [15:0] dst,
                             input int extra);
    int l1;
    int inner_at;
    int udp_at;
    int full;
    l1       = ihl1 * 4;
    inner_at = l1 + 8;
    udp_at   = inner_at + ihl2 * 4;
    full     = udp_at + 8 + extra;
    frame.delete();
    for (int i = 0; i < full; i++) frame.push_back(8'($urandom));
    frame[0]            = {4'h4, 4'(ihl1)};
    frame[l1]           = typ;
    frame[l1 + 1]       = cod;
    frame[inner_at]     = {4'h4, 4'(ihl2)};
    frame[inner_at + 9] = prot;
    frame[udp_at]       = src[15:8];
    frame[udp_at + 1]   = src[7:0];
    frame[udp_at + 2]   = dst[15:8];
    frame[udp_at + 3]   = dst[7:0];
  endtask

  task automatic cut_frame(input int len);
    while (frame.size() > len) void'(frame.pop_back());
  endtask

  function automatic int pick_ihl();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 15);
    return ($urandom_range(0, 1) != 0) ? 5 : $urandom_range(5, 15);
  endfunction

  task automatic make_random_frame();
    int          r;
    int          len;
    logic [7:0]  typ;
    logic [7:0]  cod;
    logic [7:0]  prot;
    logic [15:0] src;
    logic [15:0] dst;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      typ = TYPE_TIME_EXCEEDED; cod = CODE_IN_TRANSIT;
    end else if (r < 55) begin
      typ = TYPE_UNREACHABLE; cod = CODE_PORT_UNREACH;
    end else if (r < 72) begin
      typ = TYPE_UNREACHABLE; cod = 8'($urandom);
    end else if (r < 80) begin
      typ = TYPE_TIME_EXCEEDED; cod = 8'($urandom_range(1, 255));
    end else begin
      typ = 8'($urandom); cod = 8'($urandom);
    end
    prot = ($urandom_range(0, 7) == 0) ? 8'($urandom) : PROTO_UDP;
    src  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : sb.src_port;
    dst  = probe_port();
    case ($urandom_range(0, 15))
      0: dst = 16'($urandom);
      1: dst = dst + 16'd1;
      default: ;
    endcase
    build_reply(pick_ihl(), pick_ihl(), typ, cod, prot, src, dst, $urandom_range(0, 8));
    r = $urandom_range(0, 9);
    if (r < 2) begin
      cut_frame($urandom_range(1, frame.size()));
    end else if (r == 2) begin
      // noise: random bytes, length nibbles of any value
      frame.delete();
      len = $urandom_range(1, 80);
      repeat (len) frame.push_back(8'($urandom));
    end
  endtask

  task automatic configure_phase(input int phase);
    case (phase)
      0: begin
        // destination port wraps to zero
        write_reg(REG_SOURCE_PORT, 16'h0000);
        write_reg(REG_DEST_PORT_BASE, 16'hFFFF);
        write_reg(REG_PROBE_SEQ, 16'h0001);
      end
      1: begin
        write_reg(REG_SOURCE_PORT, 16'hFFFF);
        write_reg(REG_DEST_PORT_BASE, 16'h0000);
        write_reg(REG_PROBE_SEQ, 16'hFFFF);
      end
      2: begin
        write_reg(REG_SOURCE_PORT, 16'hA5A5);
        write_reg(REG_DEST_PORT_BASE, DEST_PORT_BASE_RESET);
        write_reg(REG_PROBE_SEQ, 16'h0000);
      end
      default: begin
        if ($urandom_range(0, 1) != 0) write_reg(REG_SOURCE_PORT, 16'($urandom));
        if ($urandom_range(0, 1) != 0) write_reg(REG_DEST_PORT_BASE, 16'($urandom));
        if ($urandom_range(0, 1) != 0) write_reg(REG_PROBE_SEQ, 16'($urandom_range(0, 64)));
      end
    endcase
  endtask

  // verdict sink: random stalls before each item
  initial begin : verdict_sink
    int       stall;
    verdict_t got;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, recv_gap_max);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {verdict, unreach_code, msg_type, msg_code};
      sb.check_verdict(got);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int phase;
    int rand_bytes;
    int rand_packets;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_SOURCE_PORT;
    cfg_data    = 16'd0;
    in_valid    = 1'b0;
    packet_byte = 8'd0;
    last_byte   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one-byte packet
    frame.delete();
    frame.push_back(8'h45);
    send_frame();
    // ICMP part of exactly eight bytes, then one short of that
    build_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP, sb.src_port,
                probe_port(), 0);
    cut_frame(28);
    send_frame();
    build_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP, sb.src_port,
                probe_port(), 0);
    cut_frame(27);
    send_frame();
    // each verdict
    build_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP, sb.src_port,
                probe_port(), 0);
    send_frame();
    build_reply(5, 5, TYPE_UNREACHABLE, CODE_PORT_UNREACH, PROTO_UDP, sb.src_port,
                probe_port(), 2);
    send_frame();
    build_reply(5, 5, TYPE_UNREACHABLE, 8'd13, PROTO_UDP, sb.src_port, probe_port(), 0);
    send_frame();
    build_reply(5, 5, TYPE_UNREACHABLE, 8'hFF, PROTO_UDP, sb.src_port, probe_port(), 0);
    send_frame();
    // time exceeded with nonzero code, and a type the block does not handle
    build_reply(5, 5, TYPE_TIME_EXCEEDED, 8'd1, PROTO_UDP, sb.src_port, probe_port(), 0);
    send_frame();
    build_reply(5, 5, 8'd8, 8'd0, PROTO_UDP, sb.src_port, probe_port(), 0);
    send_frame();
    // short of the inner header though the ports are in
    build_reply(5, 3, TYPE_UNREACHABLE, CODE_PORT_UNREACH, PROTO_UDP, sb.src_port,
                probe_port(), 0);
    cut_frame(47);
    send_frame();
    // ports end exactly on the last byte
    build_reply(5, 5, TYPE_UNREACHABLE, CODE_PORT_UNREACH, PROTO_UDP, sb.src_port,
                probe_port(), 0);
    cut_frame(52);
    send_frame();
    // longest inner header, cut one byte short of the ports, then both headers longest and whole
    build_reply(5, 15, TYPE_UNREACHABLE, CODE_PORT_UNREACH, PROTO_UDP, sb.src_port,
                probe_port(), 0);
    cut_frame(91);
    send_frame();
    build_reply(15, 15, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP, sb.src_port,
                probe_port(), 0);
    send_frame();
    // mismatches
    build_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 8'd6, sb.src_port,
                probe_port(), 0);
    send_frame();
    build_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP, sb.src_port + 16'd1,
                probe_port(), 0);
    send_frame();
    build_reply(5, 5, TYPE_UNREACHABLE, CODE_PORT_UNREACH, PROTO_UDP, sb.src_port,
                probe_port() - 16'd1, 0);
    send_frame();
    // length nibbles of zero: fields overlap
    build_reply(0, 0, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP, sb.src_port,
                probe_port(), 4);
    send_frame();

    phase        = 0;
    rand_bytes   = 0;
    rand_packets = 0;
    while (rand_bytes < 400 || rand_packets < 8) begin
      wait_drained();
      configure_phase(phase);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      repeat (2) begin
        make_random_frame();
        rand_bytes += frame.size();
        rand_packets++;
        send_frame();
      end
      phase++;
    end
    wait_drained();

    $display("Sent %0d bytes in %0d packets over %0d register writes; checked %0d verdicts",
             sb.n_bytes, sb.n_packets, reg_writes, sb.checked);
    $display("Verdicts seen: none %0d, router %0d, reached %0d, unreachable %0d",
             sb.verdict_hits[0], sb.verdict_hits[1], sb.verdict_hits[2], sb.verdict_hits[3]);
    if (sb.errors == 0) begin
      $display("icmp_probe_reply_classifier_core verification clean");
    end else begin
      $display("icmp_probe_reply_classifier_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("icmp_probe_reply_classifier_core verification failed");
    $finish;
  end

endmodule

>>> icmp_probe_reply_classifier_core.f
rtl/icmp_prc_pkg.sv
rtl/icmp_prc_capture.sv
rtl/icmp_prc_core_top.sv
sim/testbench.sv
